[rtl/best_fit_block_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define BFBA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a cause implies an effect in the same cycle.
`define BFBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a cause implies a later effect, delayed by the dly argument.
`define BFBA_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

[rtl/bfba_pkg.sv]
// Types, constants and scan helper for the best-fit block allocator.
package bfba_pkg;

    localparam int BLOCK_COUNT_DEF = 16;
    localparam int BLOCK_BYTES_DEF = 16;
    localparam int BLOCK_COUNT_MAX = 64;
    localparam int BLOCK_BYTES_MAX = 4096;

    localparam int REQ_W  = 9;
    localparam int ADDR_W = 8;
    localparam int CAP_W  = $clog2(BLOCK_COUNT_MAX * BLOCK_BYTES_MAX + (1 << REQ_W));

    typedef logic [CAP_W-1:0] t_cap;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [REQ_W-1:0]   bytes;
        logic [ADDR_W-1:0]  addr;
    } t_req;

    typedef struct packed {
        logic found;
        logic rel;
        t_cap run_start;
        t_cap run_cap;
        t_cap best_start;
        t_cap best_cap;
    } t_scan;

    typedef struct packed {
        logic en;
        t_cap start;
    } t_mark;

    function automatic t_scan close_run(input t_scan s, input logic [REQ_W-1:0] bytes);
        t_scan r;
        r = s;
        if (bytes != '0 && s.run_cap >= t_cap'(bytes) &&
            (!s.found || s.run_cap < s.best_cap)) begin
            r.found      = 1'b1;
            r.best_start = s.run_start;
            r.best_cap   = s.run_cap;
        end
        r.run_cap = '0;
        return r;
    endfunction

endpackage

[rtl/bfba_if.sv]
// Request and result channel interfaces of the best-fit block allocator.
interface bfba_in_if import bfba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, func, request_bytes, free_address, input ready);
    modport sink   (input valid, func, request_bytes, free_address, output ready);
endinterface

interface bfba_out_if import bfba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic              status;

    modport source (output valid, address, status, input ready);
    modport sink   (input valid, address, status, output ready);
endinterface

[rtl/bfba_cell.sv]
// One block of the allocator: used and run-head bits plus one stage of the scan chain.
module bfba_cell import bfba_pkg::*; #(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int INDEX       = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_tok,
    input  t_scan i_rec,
    input  t_req  i_req,
    input  t_mark i_mark,
    output logic  o_tok,
    output t_scan o_rec
);

    localparam t_cap BASE = t_cap'(INDEX * BLOCK_BYTES);
    localparam t_cap BB   = t_cap'(BLOCK_BYTES);

    logic  r_tok;
    logic  r_used;
    logic  r_head;
    t_scan r_rec;
    logic  n_used;
    logic  n_head;
    t_scan n_rec;
    logic  w_match;

    assign w_match = (t_cap'(i_req.addr) == BASE);

    always_comb begin
        n_rec  = i_rec;
        n_used = r_used;
        n_head = r_head;
        if (i_mark.en) begin
            if (BASE >= i_mark.start && BASE < i_mark.start + t_cap'(i_req.bytes)) begin
                n_used = 1'b1;
            end
            if (BASE == i_mark.start) begin
                n_head = 1'b1;
            end
        end else if (i_tok && i_req.func == FUNC_ALLOC) begin
            if (!r_used) begin
                if (i_rec.run_cap == '0) begin
                    n_rec.run_start = BASE;
                end
                n_rec.run_cap = i_rec.run_cap + BB;
            end else begin
                n_rec = close_run(i_rec, i_req.bytes);
            end
        end else if (i_tok) begin
            if (w_match && r_head) begin
                n_used    = 1'b0;
                n_head    = 1'b0;
                n_rec.found = 1'b1;
                n_rec.rel   = 1'b1;
            end else if (i_rec.rel && r_used && !r_head) begin
                n_used    = 1'b0;
                n_rec.rel = 1'b1;
            end else begin
                n_rec.rel = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_used <= 1'b0;
            r_head <= 1'b0;
        end else begin
            r_tok  <= i_tok;
            r_used <= n_used;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_rec <= n_rec;
        end
    end

    assign o_tok = r_tok;
    assign o_rec = r_rec;

endmodule

[rtl/best_fit_block_allocator.sv]
// Top level of the best-fit block allocator: control, cell chain and result register.
//
// Channels: i_in carries one request item (func 0 allocate request_bytes,
// func 1 free the run recorded at free_address); o_out returns one item per
// request with the granted byte address and a status bit (0 success).
// Both use valid/ready; an item moves when valid and ready are high at a
// rising edge of i_clk.
// Flow: one request is handled at a time. After a request is taken, the
// scan token walks the chain of block cells one cell per cycle; in the
// finish state the chosen run is marked and the result register is loaded,
// and the control returns to idle before the next request is taken.
// Reset (i_rst_n low at a clock edge): every block free, no runs recorded,
// no result pending.
// Receiver stall: the result register holds its item; one further request is
// taken and scanned, then waits for the register before marking and answering.
module best_fit_block_allocator import bfba_pkg::*; #(
    parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    bfba_in_if.sink    i_in,
    bfba_out_if.source o_out
);

    t_state            r_state;
    t_state            n_state;
    logic              r_start;
    t_req              r_req;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_address;
    logic              r_status;
    logic              n_out_valid;

    logic              w_accept;
    logic              w_load;
    logic              w_commit;
    logic              w_ready;
    t_scan             w_final;
    t_mark             w_mark;
    logic [ADDR_W-1:0] w_address;
    logic              w_status;

    logic [BLOCK_COUNT:0] w_tok;
    t_scan                w_rec [BLOCK_COUNT+1];

    assign w_accept = i_in.valid && w_ready;
    assign w_load   = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok[BLOCK_COUNT]) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ready  = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            S_IDLE:   w_ready  = 1'b1;
            S_SCAN:   w_ready  = 1'b0;
            S_FINISH: w_commit = w_load;
            default:  w_ready  = 1'b0;
        endcase
    end

    assign i_in.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.func  <= t_func'(i_in.func);
            r_req.bytes <= i_in.request_bytes;
            r_req.addr  <= i_in.free_address;
        end
    end

    assign w_tok[0] = r_start;
    assign w_rec[0] = '0;

    for (genvar g = 0; g < BLOCK_COUNT; g++) begin : g_cell
        bfba_cell #(
            .BLOCK_BYTES (BLOCK_BYTES),
            .INDEX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_rec   (w_rec[g]),
            .i_req   (r_req),
            .i_mark  (w_mark),
            .o_tok   (w_tok[g+1]),
            .o_rec   (w_rec[g+1])
        );
    end

    assign w_final = close_run(w_rec[BLOCK_COUNT], r_req.bytes);

    always_comb begin
        w_mark.en    = w_commit && r_req.func == FUNC_ALLOC && w_final.found;
        w_mark.start = w_final.best_start;
        if (r_req.func == FUNC_ALLOC) begin
            w_status  = !w_final.found;
            w_address = w_final.found ? w_final.best_start[ADDR_W-1:0] : '0;
        end else begin
            w_status  = !w_rec[BLOCK_COUNT].found;
            w_address = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_address <= w_address;
            r_status  <= w_status;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.address = r_address;
    assign o_out.status  = r_status;

`include "best_fit_block_allocator_assert.svh"

    `BFBA_ASSERT_ALWAYS(a_one_token, $onehot0(w_tok), "more than one scan token in the chain")
    `BFBA_ASSERT_DELAY(a_scan_latency, w_accept, BLOCK_COUNT + 1, w_tok[BLOCK_COUNT], "late token")
    `BFBA_ASSERT_IMPL(a_result_source, $rose(r_out_valid), $past(r_state) == S_FINISH, "result loaded outside finish")
    `BFBA_ASSERT_IMPL(a_tail_in_scan, w_tok[BLOCK_COUNT], r_state == S_SCAN, "scan token at tail outside scan")

endmodule
